// ===== rtl/mlnc_pkg.sv =====
// Shared constants, register codes and types for the microlens nearest-center block.
package mlnc_pkg;

  // Pixel coordinate width and fractional bits of the lattice fixed point
  localparam int COORD_BITS = 14;
  localparam int FRAC_BITS  = 16;

  // Coefficient, center and scale formats
  localparam int COEF_W     = 32;
  localparam int SCALE_W    = 32;
  localparam int SCALE_FRAC = 28;
  localparam int IDX_W      = 24;
  localparam int OFF_W      = FRAC_BITS + 2;

  // Configuration port
  localparam int CFG_W     = 2 * COEF_W;
  localparam int CFG_IDX_W = 3;

  // Register stages from input to result
  localparam int NUM_STAGES = 11;

  // Reset values: identity transforms, offset scale of 0.2
  localparam logic [CFG_W-1:0]   COEF_ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0]   COEF_ONE_HI = CFG_W'(1) << (FRAC_BITS + COEF_W);
  localparam logic [SCALE_W-1:0] SCALE_RST   = SCALE_W'(53687091);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_U_TERMS  = 3'd0,
    REG_FWD_V_TERMS  = 3'd1,
    REG_FWD_OFFSETS  = 3'd2,
    REG_INV_X_TERMS  = 3'd3,
    REG_INV_Y_TERMS  = 3'd4,
    REG_INV_OFFSETS  = 3'd5,
    REG_OFFSET_SCALE = 3'd6
  } cfg_reg_t;

  // One lattice candidate: center, saturated distance and its magnitude
  typedef struct packed {
    logic signed [COEF_W-1:0] cx;
    logic signed [COEF_W-1:0] cy;
    logic signed [COEF_W-1:0] dx;
    logic signed [COEF_W-1:0] dy;
    logic        [COEF_W-1:0] mx;
    logic        [COEF_W-1:0] my;
  } cand_t;

endpackage

// ===== rtl/microlens_nearest_center.sv =====
// Top level of the microlens nearest-center pipeline.
//
// Maps a sensor pixel into lens-lattice space, evaluates the four floor/ceil
// lattice corners back in pixel space and returns the nearest lens center
// together with the pixel offset from it scaled by 2/pitch (saturated to +-2).
// The pipeline takes one transaction every clock cycle (busy stays low) and
// delivers each result marked by a one-cycle out_valid pulse; the receiver
// cannot stall, so results are never held. The pipeline has eleven register
// stages: forward products, lattice floor/ceil, inverse products, center sums,
// distance, squares, distance sums, two compare levels, offset scaling and
// rounding. Configuration registers are written through cfg_we/cfg_index/
// cfg_wdata; write them only while no transaction is in flight (the block
// does not enforce this). Writes to unused indexes are dropped.
module microlens_nearest_center (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mlnc_pkg::COORD_BITS-1:0]       in_pixel_x,
  input  logic [mlnc_pkg::COORD_BITS-1:0]       in_pixel_y,
  output logic                                  out_valid,
  output logic signed [mlnc_pkg::COEF_W-1:0]    out_center_x,
  output logic signed [mlnc_pkg::COEF_W-1:0]    out_center_y,
  output logic signed [mlnc_pkg::OFF_W-1:0]     out_offset_x,
  output logic signed [mlnc_pkg::OFF_W-1:0]     out_offset_y,
  input  logic                                  cfg_we,
  input  logic [mlnc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mlnc_pkg::CFG_W-1:0]            cfg_wdata
);
  import mlnc_pkg::*;

  localparam int FWD_PROD_W = COORD_BITS + 1 + COEF_W;
  localparam int FWD_SUM_W  = FWD_PROD_W + 2;
  localparam int FL_W       = FWD_SUM_W - FRAC_BITS;
  localparam int INV_PROD_W = IDX_W + COEF_W;
  localparam int INV_SUM_W  = INV_PROD_W + 2;
  localparam int PIX_W      = COORD_BITS + FRAC_BITS;
  localparam int DIFF_W     = ((PIX_W > COEF_W) ? PIX_W : COEF_W) + 2;
  localparam int SQ_W       = 2 * COEF_W;
  localparam int PROD_W     = COEF_W + SCALE_W;
  localparam int RND_W      = PROD_W - SCALE_FRAC;

  localparam logic signed [FL_W:0] IDX_HI_X =
    {{(FL_W + 2 - IDX_W){1'b0}}, {(IDX_W - 1){1'b1}}};
  localparam logic signed [FL_W:0] IDX_LO_X =
    {{(FL_W + 2 - IDX_W){1'b1}}, {(IDX_W - 1){1'b0}}};
  localparam logic signed [IDX_W-1:0] IDX_MAX_V = {1'b0, {(IDX_W - 1){1'b1}}};
  localparam logic signed [IDX_W-1:0] IDX_MIN_V = {1'b1, {(IDX_W - 1){1'b0}}};

  localparam logic signed [INV_SUM_W-1:0] CTR_HI_X =
    {{(INV_SUM_W - COEF_W + 1){1'b0}}, {(COEF_W - 1){1'b1}}};
  localparam logic signed [INV_SUM_W-1:0] CTR_LO_X =
    {{(INV_SUM_W - COEF_W + 1){1'b1}}, {(COEF_W - 1){1'b0}}};
  localparam logic signed [DIFF_W-1:0] DIFF_HI_X =
    {{(DIFF_W - COEF_W + 1){1'b0}}, {(COEF_W - 1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] DIFF_LO_X =
    {{(DIFF_W - COEF_W + 1){1'b1}}, {(COEF_W - 1){1'b0}}};
  localparam logic signed [COEF_W-1:0] C_MAX_V = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam logic signed [COEF_W-1:0] C_MIN_V = {1'b1, {(COEF_W - 1){1'b0}}};

  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (SCALE_FRAC - 1);
  localparam logic [RND_W-1:0]  OFF_NEG_LIM = RND_W'(1) << (OFF_W - 1);
  localparam logic [RND_W-1:0]  OFF_POS_LIM = (RND_W'(1) << (OFF_W - 1)) - RND_W'(1);
  localparam logic signed [OFF_W-1:0] OFF_MAX_V = {1'b0, {(OFF_W - 1){1'b1}}};
  localparam logic signed [OFF_W-1:0] OFF_MIN_V = {1'b1, {(OFF_W - 1){1'b0}}};

  // Saturate a lattice index to the index range
  function automatic logic signed [IDX_W-1:0] sat_idx(input logic signed [FL_W:0] v);
    if (v > IDX_HI_X) begin
      return IDX_MAX_V;
    end else if (v < IDX_LO_X) begin
      return IDX_MIN_V;
    end
    return $signed(v[IDX_W-1:0]);
  endfunction

  // Saturate a center sum to the signed center range
  function automatic logic signed [COEF_W-1:0] sat_ctr(input logic signed [INV_SUM_W-1:0] v);
    if (v > CTR_HI_X) begin
      return C_MAX_V;
    end else if (v < CTR_LO_X) begin
      return C_MIN_V;
    end
    return $signed(v[COEF_W-1:0]);
  endfunction

  // Saturate a distance to the signed center range
  function automatic logic signed [COEF_W-1:0] sat_diff(input logic signed [DIFF_W-1:0] v);
    if (v > DIFF_HI_X) begin
      return C_MAX_V;
    end else if (v < DIFF_LO_X) begin
      return C_MIN_V;
    end
    return $signed(v[COEF_W-1:0]);
  endfunction

  // Magnitude of the saturated distance, taken from the raw difference
  function automatic logic [COEF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] neg;
    neg = -v;
    if (v > DIFF_HI_X) begin
      return C_MAX_V;
    end else if (v < DIFF_LO_X) begin
      return C_MIN_V;
    end else if (v[DIFF_W-1]) begin
      return neg[COEF_W-1:0];
    end
    return v[COEF_W-1:0];
  endfunction

  // Reapply the sign to a rounded offset magnitude and saturate
  function automatic logic signed [OFF_W-1:0] sat_off(input logic neg,
                                                      input logic [RND_W-1:0] p);
    logic [OFF_W-1:0] lo;
    lo = p[OFF_W-1:0];
    if (neg) begin
      if (p > OFF_NEG_LIM) begin
        return OFF_MIN_V;
      end
      return $signed(-lo);
    end
    if (p > OFF_POS_LIM) begin
      return OFF_MAX_V;
    end
    return $signed(lo);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]   fwd_u_terms_r;
  logic [CFG_W-1:0]   fwd_v_terms_r;
  logic [CFG_W-1:0]   fwd_offsets_r;
  logic [CFG_W-1:0]   inv_x_terms_r;
  logic [CFG_W-1:0]   inv_y_terms_r;
  logic [CFG_W-1:0]   inv_offsets_r;
  logic [SCALE_W-1:0] offset_scale_r;

  // Write the addressed register; drop unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_u_terms_r  <= COEF_ONE_LO;
      fwd_v_terms_r  <= COEF_ONE_HI;
      fwd_offsets_r  <= '0;
      inv_x_terms_r  <= COEF_ONE_LO;
      inv_y_terms_r  <= COEF_ONE_HI;
      inv_offsets_r  <= '0;
      offset_scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FWD_U_TERMS:  fwd_u_terms_r  <= cfg_wdata;
        REG_FWD_V_TERMS:  fwd_v_terms_r  <= cfg_wdata;
        REG_FWD_OFFSETS:  fwd_offsets_r  <= cfg_wdata;
        REG_INV_X_TERMS:  inv_x_terms_r  <= cfg_wdata;
        REG_INV_Y_TERMS:  inv_y_terms_r  <= cfg_wdata;
        REG_INV_OFFSETS:  inv_offsets_r  <= cfg_wdata;
        REG_OFFSET_SCALE: offset_scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_W-1:0] fu_x, fu_y, fv_x, fv_y, fo_u, fo_v;
  logic signed [COEF_W-1:0] ix_u, ix_v, iy_u, iy_v, io_x, io_y;

  assign fu_x = $signed(fwd_u_terms_r[COEF_W-1:0]);
  assign fu_y = $signed(fwd_u_terms_r[CFG_W-1:COEF_W]);
  assign fv_x = $signed(fwd_v_terms_r[COEF_W-1:0]);
  assign fv_y = $signed(fwd_v_terms_r[CFG_W-1:COEF_W]);
  assign fo_u = $signed(fwd_offsets_r[COEF_W-1:0]);
  assign fo_v = $signed(fwd_offsets_r[CFG_W-1:COEF_W]);
  assign ix_u = $signed(inv_x_terms_r[COEF_W-1:0]);
  assign ix_v = $signed(inv_x_terms_r[CFG_W-1:COEF_W]);
  assign iy_u = $signed(inv_y_terms_r[COEF_W-1:0]);
  assign iy_v = $signed(inv_y_terms_r[CFG_W-1:COEF_W]);
  assign io_x = $signed(inv_offsets_r[COEF_W-1:0]);
  assign io_y = $signed(inv_offsets_r[CFG_W-1:COEF_W]);

  // ---------------------------------------------------------------------------
  // Valid bits travel with the data; the pipeline never stalls
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NUM_STAGES-2:0], start & ~busy};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: forward products
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS:0]     xs, ys;
  logic signed [FWD_PROD_W-1:0]   s1_ux_r, s1_uy_r, s1_vx_r, s1_vy_r;
  logic [COORD_BITS-1:0]          s1_x_r, s1_y_r;

  assign xs = $signed({1'b0, in_pixel_x});
  assign ys = $signed({1'b0, in_pixel_y});

  always_ff @(posedge clk) begin
    s1_ux_r <= xs * fu_x;
    s1_uy_r <= ys * fu_y;
    s1_vx_r <= xs * fv_x;
    s1_vy_r <= ys * fv_y;
    s1_x_r  <= in_pixel_x;
    s1_y_r  <= in_pixel_y;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: lattice coordinates, floor and ceil, index saturation
  // ---------------------------------------------------------------------------
  logic signed [FWD_SUM_W-1:0] u_sum, v_sum;
  logic signed [FL_W-1:0]      u_fl, v_fl;
  logic [FL_W:0]               u_ce, v_ce;
  logic                        u_frac, v_frac;
  logic signed [IDX_W-1:0]     s2_u_r [2];
  logic signed [IDX_W-1:0]     s2_v_r [2];
  logic [COORD_BITS-1:0]       s2_x_r, s2_y_r;

  always_comb begin
    u_sum  = s1_ux_r + s1_uy_r + fo_u;
    v_sum  = s1_vx_r + s1_vy_r + fo_v;
    u_fl   = $signed(u_sum[FWD_SUM_W-1:FRAC_BITS]);
    v_fl   = $signed(v_sum[FWD_SUM_W-1:FRAC_BITS]);
    u_frac = |u_sum[FRAC_BITS-1:0];
    v_frac = |v_sum[FRAC_BITS-1:0];
    u_ce   = (FL_W + 1)'(u_fl) + (FL_W + 1)'(u_frac);
    v_ce   = (FL_W + 1)'(v_fl) + (FL_W + 1)'(v_frac);
  end

  always_ff @(posedge clk) begin
    s2_u_r[0] <= sat_idx((FL_W + 1)'(u_fl));
    s2_u_r[1] <= sat_idx($signed(u_ce));
    s2_v_r[0] <= sat_idx((FL_W + 1)'(v_fl));
    s2_v_r[1] <= sat_idx($signed(v_ce));
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: inverse products for floor and ceil of each lattice axis
  // ---------------------------------------------------------------------------
  logic signed [INV_PROD_W-1:0] s3_xu_r [2];
  logic signed [INV_PROD_W-1:0] s3_xv_r [2];
  logic signed [INV_PROD_W-1:0] s3_yu_r [2];
  logic signed [INV_PROD_W-1:0] s3_yv_r [2];
  logic [COORD_BITS-1:0]        s3_x_r, s3_y_r;

  for (genvar j = 0; j < 2; j++) begin : g_inv_mul
    always_ff @(posedge clk) begin
      s3_xu_r[j] <= s2_u_r[j] * ix_u;
      s3_xv_r[j] <= s2_v_r[j] * ix_v;
      s3_yu_r[j] <= s2_u_r[j] * iy_u;
      s3_yv_r[j] <= s2_v_r[j] * iy_v;
    end
  end

  always_ff @(posedge clk) begin
    s3_x_r <= s2_x_r;
    s3_y_r <= s2_y_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: candidate centers, order (uf,vf) (uf,vc) (uc,vf) (uc,vc)
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0] s4_cx_r [4];
  logic signed [COEF_W-1:0] s4_cy_r [4];
  logic [PIX_W-1:0]         s4_px_r, s4_py_r;

  for (genvar k = 0; k < 4; k++) begin : g_center
    logic signed [INV_SUM_W-1:0] cx_sum, cy_sum;

    assign cx_sum = s3_xu_r[k / 2] + s3_xv_r[k % 2] + io_x;
    assign cy_sum = s3_yu_r[k / 2] + s3_yv_r[k % 2] + io_y;

    always_ff @(posedge clk) begin
      s4_cx_r[k] <= sat_ctr(cx_sum);
      s4_cy_r[k] <= sat_ctr(cy_sum);
    end
  end

  always_ff @(posedge clk) begin
    s4_px_r <= {s3_x_r, {FRAC_BITS{1'b0}}};
    s4_py_r <= {s3_y_r, {FRAC_BITS{1'b0}}};
  end

  // ---------------------------------------------------------------------------
  // Stage 5: saturated distances and their magnitudes
  // ---------------------------------------------------------------------------
  cand_t s5_cand_r [4];

  for (genvar k = 0; k < 4; k++) begin : g_diff
    logic signed [DIFF_W-1:0] dx_raw, dy_raw;

    assign dx_raw = $signed(DIFF_W'(s4_px_r)) - DIFF_W'(s4_cx_r[k]);
    assign dy_raw = $signed(DIFF_W'(s4_py_r)) - DIFF_W'(s4_cy_r[k]);

    always_ff @(posedge clk) begin
      s5_cand_r[k].cx <= s4_cx_r[k];
      s5_cand_r[k].cy <= s4_cy_r[k];
      s5_cand_r[k].dx <= sat_diff(dx_raw);
      s5_cand_r[k].dy <= sat_diff(dy_raw);
      s5_cand_r[k].mx <= mag_diff(dx_raw);
      s5_cand_r[k].my <= mag_diff(dy_raw);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: squares; stage 7: squared distances
  // ---------------------------------------------------------------------------
  cand_t           s6_cand_r [4];
  logic [SQ_W-1:0] s6_sqx_r  [4];
  logic [SQ_W-1:0] s6_sqy_r  [4];
  cand_t           s7_cand_r [4];
  logic [SQ_W-1:0] s7_dist_r [4];

  for (genvar k = 0; k < 4; k++) begin : g_dist
    always_ff @(posedge clk) begin
      s6_sqx_r[k]  <= s5_cand_r[k].mx * s5_cand_r[k].mx;
      s6_sqy_r[k]  <= s5_cand_r[k].my * s5_cand_r[k].my;
      s6_cand_r[k] <= s5_cand_r[k];
      s7_dist_r[k] <= s6_sqx_r[k] + s6_sqy_r[k];
      s7_cand_r[k] <= s6_cand_r[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: pairwise minimum; the earlier candidate wins ties
  // ---------------------------------------------------------------------------
  cand_t           s8_cand_a_r, s8_cand_b_r;
  logic [SQ_W-1:0] s8_dist_a_r, s8_dist_b_r;

  always_ff @(posedge clk) begin
    if (s7_dist_r[1] < s7_dist_r[0]) begin
      s8_cand_a_r <= s7_cand_r[1];
      s8_dist_a_r <= s7_dist_r[1];
    end else begin
      s8_cand_a_r <= s7_cand_r[0];
      s8_dist_a_r <= s7_dist_r[0];
    end
    if (s7_dist_r[3] < s7_dist_r[2]) begin
      s8_cand_b_r <= s7_cand_r[3];
      s8_dist_b_r <= s7_dist_r[3];
    end else begin
      s8_cand_b_r <= s7_cand_r[2];
      s8_dist_b_r <= s7_dist_r[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: final minimum
  // ---------------------------------------------------------------------------
  cand_t s9_cand_r;

  always_ff @(posedge clk) begin
    s9_cand_r <= (s8_dist_b_r < s8_dist_a_r) ? s8_cand_b_r : s8_cand_a_r;
  end

  // ---------------------------------------------------------------------------
  // Stage 10: scale offset magnitudes by 2/pitch
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]        s10_sx_r, s10_sy_r;
  logic                     s10_negx_r, s10_negy_r;
  logic signed [COEF_W-1:0] s10_cx_r, s10_cy_r;

  always_ff @(posedge clk) begin
    s10_sx_r   <= s9_cand_r.mx * offset_scale_r;
    s10_sy_r   <= s9_cand_r.my * offset_scale_r;
    s10_negx_r <= s9_cand_r.dx[COEF_W-1];
    s10_negy_r <= s9_cand_r.dy[COEF_W-1];
    s10_cx_r   <= s9_cand_r.cx;
    s10_cy_r   <= s9_cand_r.cy;
  end

  // ---------------------------------------------------------------------------
  // Stage 11: round half away from zero, reapply sign, saturate
  // ---------------------------------------------------------------------------
  logic [PROD_W-1:0]        rnd_x, rnd_y;
  logic signed [COEF_W-1:0] out_cx_r, out_cy_r;
  logic signed [OFF_W-1:0]  out_ox_r, out_oy_r;

  assign rnd_x = s10_sx_r + RND_HALF;
  assign rnd_y = s10_sy_r + RND_HALF;

  always_ff @(posedge clk) begin
    out_cx_r <= s10_cx_r;
    out_cy_r <= s10_cy_r;
    out_ox_r <= sat_off(s10_negx_r, rnd_x[PROD_W-1:SCALE_FRAC]);
    out_oy_r <= sat_off(s10_negy_r, rnd_y[PROD_W-1:SCALE_FRAC]);
  end

  assign out_valid    = vld_r[NUM_STAGES-1];
  assign out_center_x = out_cx_r;
  assign out_center_y = out_cy_r;
  assign out_offset_x = out_ox_r;
  assign out_offset_y = out_oy_r;

endmodule
